[sv/slbm_pkg.sv]
// Package for the serial loaded bank mapper: codes, widths and controller/datapath types.
package slbm_pkg;

    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int REGION_W = 3;
    localparam int MAP_W    = 18;
    localparam int MIR_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int BANK_W   = 4;
    localparam int REG5_W   = 5;

    localparam logic [MODE_W-1:0] MODE_CPU_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CPU_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PPU_READ  = 2'd2;

    localparam logic [REGION_W-1:0] REGION_NONE    = 3'd0;
    localparam logic [REGION_W-1:0] REGION_PRG_RAM = 3'd1;
    localparam logic [REGION_W-1:0] REGION_PRG_ROM = 3'd2;
    localparam logic [REGION_W-1:0] REGION_CHR     = 3'd3;
    localparam logic [REGION_W-1:0] REGION_REG_WR  = 3'd4;

    localparam logic [MIR_W-1:0] MIR_ONE_LOW  = 2'd0;
    localparam logic [MIR_W-1:0] MIR_ONE_HIGH = 2'd1;
    localparam logic [MIR_W-1:0] MIR_HORIZ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM_BANKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM    = 1'd1;

    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG      = 2'd3;

    localparam logic [REG5_W-1:0] CONTROL_RESET = 5'h0C;
    localparam logic [REG5_W-1:0] PRG_BANKS_RESET = 5'd16;
    localparam logic [REG5_W-1:0] PRG_BANKS_MAX   = 5'd16;
    localparam logic [2:0]        SHIFT_FULL      = 3'd5;

    typedef struct packed {
        logic       accept;
        logic       step;
        logic [1:0] bit_idx;
        logic       load;
    } slbm_cmd_t;

    typedef struct packed {
        logic out_free;
    } slbm_sts_t;

endpackage

[sv/slbm_if.sv]
// Channel interfaces: bus access requests, mapped results and configuration writes.
interface slbm_req_if;
    logic                              valid;
    logic                              ready;
    logic [slbm_pkg::MODE_W-1:0]       mode;
    logic [slbm_pkg::ADDR_W-1:0]       address;
    logic [slbm_pkg::DATA_W-1:0]       write_value;

    modport source (output valid, output mode, output address, output write_value,
                    input ready);
    modport sink   (input valid, input mode, input address, input write_value,
                    output ready);
endinterface

interface slbm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [slbm_pkg::REGION_W-1:0]     region;
    logic [slbm_pkg::MAP_W-1:0]        mapped_address;
    logic [slbm_pkg::MIR_W-1:0]        mirroring;

    modport source (output valid, output region, output mapped_address, output mirroring,
                    input ready);
    modport sink   (input valid, input region, input mapped_address, input mirroring,
                    output ready);
endinterface

interface slbm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [slbm_pkg::CFG_IDX_W-1:0]    index;
    logic [slbm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/slbm_ctrl.sv]
// Sequencer: accepts an access, runs the four-step bank remainder, then loads the result.
module slbm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  slbm_pkg::slbm_sts_t    sts,
    output slbm_pkg::slbm_cmd_t    cmd
);
    import slbm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.accept  = 1'b0;
        cmd.step    = 1'b0;
        cmd.bit_idx = cnt_reg;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = 2'd3;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 2'd1;
                if (cnt_reg == 2'd0)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[sv/slbm_dp.sv]
// Datapath: mapper registers, serial loader, bank remainder unit and result register.
module slbm_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  slbm_pkg::slbm_cmd_t                   cmd,
    output slbm_pkg::slbm_sts_t                   sts,
    input  logic [slbm_pkg::MODE_W-1:0]           req_mode,
    input  logic [slbm_pkg::ADDR_W-1:0]           req_address,
    input  logic [slbm_pkg::DATA_W-1:0]           req_write_value,
    input  logic                                  cfg_we,
    input  logic [slbm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [slbm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic [slbm_pkg::REGION_W-1:0]         rsp_region,
    output logic [slbm_pkg::MAP_W-1:0]            rsp_mapped_address,
    output logic [slbm_pkg::MIR_W-1:0]            rsp_mirroring
);
    import slbm_pkg::*;

    logic [REG5_W-1:0]   prg_rom_banks_reg;
    logic                chr_is_ram_reg;
    logic [REG5_W-1:0]   shift_bits_reg, shift_bits_next;
    logic [2:0]          shift_count_reg, shift_count_next;
    logic [REG5_W-1:0]   control_reg, control_next;
    logic [REG5_W-1:0]   chr_low_reg, chr_low_next;
    logic [REG5_W-1:0]   chr_high_reg, chr_high_next;
    logic [REG5_W-1:0]   prg_bank_reg, prg_bank_next;

    logic [MODE_W-1:0]   mode_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [BANK_W-1:0]   dividend_reg;
    logic [REG5_W-1:0]   divisor_reg;
    logic [REG5_W-1:0]   rem_reg, rem_next;

    logic                out_valid_reg;
    logic [REGION_W-1:0] region_reg, region_next;
    logic [MAP_W-1:0]    mapped_reg, mapped_next;
    logic [MIR_W-1:0]    mirror_reg, mirror_next;

    logic [REG5_W-1:0]   eff_banks;
    logic [BANK_W-1:0]   last_bank;
    logic [BANK_W-1:0]   prg_sel_bank;
    logic                high_half;
    logic [REG5_W-1:0]   shifted;
    logic [2:0]          count_inc;
    logic                serial_wr;
    logic [REG5_W-1:0]   rem_shift;
    logic [REG5_W-1:0]   chr_bank;
    logic [12:0]         chr_addr;

    assign sts.out_free = !out_valid_reg || rsp_ready;

    // PRG size clamped to 1..16
    always_comb
    begin
        if (prg_rom_banks_reg == '0)
            eff_banks = 5'd1;
        else if (prg_rom_banks_reg > PRG_BANKS_MAX)
            eff_banks = PRG_BANKS_MAX;
        else
            eff_banks = prg_rom_banks_reg;
    end

    assign last_bank = BANK_W'(eff_banks - 5'd1);
    assign high_half = req_address[14];

    always_comb
    begin
        case (control_reg[3:2])
            2'd2:    prg_sel_bank = high_half ? prg_bank_reg[3:0] : '0;
            2'd3:    prg_sel_bank = high_half ? last_bank : prg_bank_reg[3:0];
            default: prg_sel_bank = {prg_bank_reg[3:1], high_half};
        endcase
    end

    // serial loader
    assign serial_wr = cmd.accept && (req_mode == MODE_CPU_WRITE) && req_address[15];
    assign shifted   = {req_write_value[0], shift_bits_reg[4:1]};
    assign count_inc = shift_count_reg + 3'd1;

    always_comb
    begin
        shift_bits_next  = shift_bits_reg;
        shift_count_next = shift_count_reg;
        control_next     = control_reg;
        chr_low_next     = chr_low_reg;
        chr_high_next    = chr_high_reg;
        prg_bank_next    = prg_bank_reg;
        if (serial_wr)
        begin
            if (req_write_value[7])
            begin
                shift_bits_next  = '0;
                shift_count_next = '0;
                control_next     = control_reg | CONTROL_RESET;
            end
            else if (count_inc == SHIFT_FULL)
            begin
                shift_bits_next  = '0;
                shift_count_next = '0;
                unique case (req_address[14:13])
                    SEL_CONTROL:  control_next  = shifted;
                    SEL_CHR_LOW:  chr_low_next  = shifted;
                    SEL_CHR_HIGH: chr_high_next = shifted;
                    SEL_PRG:      prg_bank_next = shifted;
                    default:      prg_bank_next = shifted;
                endcase
            end
            else
            begin
                shift_bits_next  = shifted;
                shift_count_next = count_inc;
            end
        end
    end

    // restoring remainder, one dividend bit per step
    assign rem_shift = {rem_reg[3:0], dividend_reg[cmd.bit_idx]};

    always_comb
    begin
        if (cmd.accept)
            rem_next = '0;
        else if (cmd.step)
            rem_next = (rem_shift >= divisor_reg) ? rem_shift - divisor_reg : rem_shift;
        else
            rem_next = rem_reg;
    end

    // result formation
    assign chr_addr = addr_reg[12:0];

    always_comb
    begin
        if (!control_reg[4])
            chr_bank = {chr_low_reg[4:1], chr_addr[12]};
        else
            chr_bank = chr_addr[12] ? chr_high_reg : chr_low_reg;
    end

    always_comb
    begin
        region_next = REGION_NONE;
        mapped_next = '0;
        case (mode_reg)
            MODE_CPU_READ:
            begin
                if (addr_reg[15])
                begin
                    region_next = REGION_PRG_ROM;
                    mapped_next = {rem_reg[3:0], addr_reg[13:0]};
                end
                else if (addr_reg[14:13] == 2'b11)
                begin
                    region_next = REGION_PRG_RAM;
                    mapped_next = {5'd0, addr_reg[12:0]};
                end
            end
            MODE_CPU_WRITE:
            begin
                if (addr_reg[15])
                    region_next = REGION_REG_WR;
                else if (addr_reg[14:13] == 2'b11)
                begin
                    region_next = REGION_PRG_RAM;
                    mapped_next = {5'd0, addr_reg[12:0]};
                end
            end
            MODE_PPU_READ:
            begin
                region_next = REGION_CHR;
                if (chr_is_ram_reg)
                    mapped_next = {5'd0, chr_addr};
                else
                    mapped_next = {1'b0, chr_bank, chr_addr[11:0]};
            end
            default:
            begin
                region_next = REGION_NONE;
            end
        endcase
    end

    always_comb
    begin
        case (control_reg[1:0])
            2'd1:    mirror_next = MIR_ONE_HIGH;
            2'd3:    mirror_next = MIR_HORIZ;
            default: mirror_next = MIR_ONE_LOW;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_rom_banks_reg <= PRG_BANKS_RESET;
            chr_is_ram_reg    <= 1'b0;
            shift_bits_reg    <= '0;
            shift_count_reg   <= '0;
            control_reg       <= CONTROL_RESET;
            chr_low_reg       <= '0;
            chr_high_reg      <= '0;
            prg_bank_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PRG_ROM_BANKS: prg_rom_banks_reg <= cfg_data;
                    CFG_CHR_IS_RAM:    chr_is_ram_reg    <= cfg_data[0];
                    default:           chr_is_ram_reg    <= cfg_data[0];
                endcase
            end
            shift_bits_reg  <= shift_bits_next;
            shift_count_reg <= shift_count_next;
            control_reg     <= control_next;
            chr_low_reg     <= chr_low_next;
            chr_high_reg    <= chr_high_next;
            prg_bank_reg    <= prg_bank_next;
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg     <= req_mode;
            addr_reg     <= req_address;
            dividend_reg <= prg_sel_bank;
            divisor_reg  <= eff_banks;
        end
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            region_reg <= region_next;
            mapped_reg <= mapped_next;
            mirror_reg <= mirror_next;
        end
    end

    assign rsp_valid          = out_valid_reg;
    assign rsp_region         = region_reg;
    assign rsp_mapped_address = mapped_reg;
    assign rsp_mirroring      = mirror_reg;

endmodule

[sv/serial_loaded_bank_mapper.sv]
// Serial loaded bank mapper top level: sequencer plus datapath.
// Any serial register write is applied at the transfer of a bus access. The sequencer then
// computes the bank remainder modulo the PRG ROM size, one dividend bit per cycle, and then
// loads the result register, after which the result is valid. A result waits in that
// register until it is taken, and the load of the next result waits for it. The input is
// ready again once the result is loaded, so a new access is not accepted before the result
// of the last one is loaded. The configuration port is always ready; the user must write it
// only while no access is in flight, as the block itself does not enforce this.
module serial_loaded_bank_mapper (
    input  logic       clk,
    input  logic       rst_n,
    slbm_req_if.sink   req,
    slbm_rsp_if.source rsp,
    slbm_cfg_if.sink   cfg
);
    import slbm_pkg::*;

    slbm_cmd_t cmd;
    slbm_sts_t sts;

    assign cfg.ready = 1'b1;

    slbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    slbm_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .req_mode           (req.mode),
        .req_address        (req.address),
        .req_write_value    (req.write_value),
        .cfg_we             (cfg.valid),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .rsp_region         (rsp.region),
        .rsp_mapped_address (rsp.mapped_address),
        .rsp_mirroring      (rsp.mirroring)
    );

endmodule

[dv/bank_map_checker.sv]
// Checker for the bank mapper: predicts each access result and compares the response channel.
`timescale 1ns / 1ps

module bank_map_checker (
    input  logic clk,
    input  logic rst_n,
    slbm_req_if  req,
    slbm_rsp_if  rsp,
    slbm_cfg_if  cfg,
    output int   mismatches,
    output int   outstanding
);
    import slbm_pkg::*;

    localparam logic [1:0] PRG_FIX_LOW  = 2'd2;
    localparam logic [1:0] PRG_FIX_HIGH = 2'd3;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [MAP_W-1:0]    offset;
        logic [MIR_W-1:0]    mirror;
    } bus_result_t;

    logic [REG5_W-1:0] rom_banks;
    logic              chr_ram;
    logic [REG5_W-1:0] shifter;
    logic [2:0]        shift_n;
    logic [REG5_W-1:0] ctrl;
    logic [REG5_W-1:0] chr_lo;
    logic [REG5_W-1:0] chr_hi;
    logic [REG5_W-1:0] prg_sel;
    bus_result_t       expected_q[$];
    int                fails = 0;

    assign mismatches = fails;

    function automatic logic [MAP_W-1:0] rom_offset(input logic [ADDR_W-1:0] a);
        int n;
        int bank;
        n = (rom_banks == 0) ? 1 : ((rom_banks > PRG_BANKS_MAX) ? 16 : int'(rom_banks));
        case (ctrl[3:2])
            PRG_FIX_LOW:  bank = a[14] ? int'(prg_sel[3:0]) : 0;
            PRG_FIX_HIGH: bank = a[14] ? n - 1 : int'(prg_sel[3:0]);
            default:      bank = int'({prg_sel[3:1], 1'b0}) + int'(a[14]);
        endcase
        bank = bank % n;
        return MAP_W'((bank << 14) | int'(a[13:0]));
    endfunction

    function automatic logic [MAP_W-1:0] chr_offset(input logic [ADDR_W-1:0] a);
        int bank;
        if (chr_ram)
            return MAP_W'(a[12:0]);
        if (!ctrl[4])
            bank = int'({chr_lo[4:1], 1'b0}) + int'(a[12]);
        else
            bank = a[12] ? int'(chr_hi) : int'(chr_lo);
        return MAP_W'((bank << 12) | int'(a[11:0]));
    endfunction

    function automatic logic [MIR_W-1:0] mirror_now();
        case (ctrl[1:0])
            2'd1:    return MIR_ONE_HIGH;
            2'd3:    return MIR_HORIZ;
            default: return MIR_ONE_LOW;
        endcase
    endfunction

    task shift_in(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] v);
        if (v[7])
        begin
            shifter = '0;
            shift_n = '0;
            ctrl    = ctrl | CONTROL_RESET;
        end
        else
        begin
            shifter = {v[0], shifter[4:1]};
            shift_n = shift_n + 3'd1;
            if (shift_n == SHIFT_FULL)
            begin
                case (a[14:13])
                    SEL_CONTROL:  ctrl    = shifter;
                    SEL_CHR_LOW:  chr_lo  = shifter;
                    SEL_CHR_HIGH: chr_hi  = shifter;
                    SEL_PRG:      prg_sel = shifter;
                endcase
                shifter = '0;
                shift_n = '0;
            end
        end
    endtask

    task predict_access(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
                        input logic [DATA_W-1:0] v);
        bus_result_t r;
        r = '0;
        case (m)
            MODE_CPU_READ:
            begin
                if (a >= 16'h8000)
                begin
                    r.region = REGION_PRG_ROM;
                    r.offset = rom_offset(a);
                end
                else if (a >= 16'h6000)
                begin
                    r.region = REGION_PRG_RAM;
                    r.offset = MAP_W'(a - 16'h6000);
                end
            end
            MODE_CPU_WRITE:
            begin
                if (a >= 16'h8000)
                begin
                    r.region = REGION_REG_WR;
                    shift_in(a, v);
                end
                else if (a >= 16'h6000)
                begin
                    r.region = REGION_PRG_RAM;
                    r.offset = MAP_W'(a - 16'h6000);
                end
            end
            MODE_PPU_READ:
            begin
                r.region = REGION_CHR;
                r.offset = chr_offset(a);
            end
            default: ;
        endcase
        r.mirror = mirror_now();
        expected_q.push_back(r);
    endtask

    task note_mismatch(input string field, input int want, input int got);
        fails++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_result_t seen;
        bus_result_t want;
        if (!rst_n)
        begin
            rom_banks = PRG_BANKS_RESET;
            chr_ram   = 1'b0;
            shifter   = '0;
            shift_n   = '0;
            ctrl      = CONTROL_RESET;
            chr_lo    = '0;
            chr_hi    = '0;
            prg_sel   = '0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                seen.region = rsp.region;
                seen.offset = rsp.mapped_address;
                seen.mirror = rsp.mirroring;
                if (expected_q.size() == 0)
                    note_mismatch("result with no access pending, region", 0, seen.region);
                else
                begin
                    want = expected_q.pop_front();
                    if (seen.region !== want.region)
                        note_mismatch("region", want.region, seen.region);
                    if (seen.offset !== want.offset)
                        note_mismatch("mapped_address", want.offset, seen.offset);
                    if (seen.mirror !== want.mirror)
                        note_mismatch("mirroring", want.mirror, seen.mirror);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_PRG_ROM_BANKS: rom_banks = cfg.data;
                    CFG_CHR_IS_RAM:    chr_ram   = cfg.data[0];
                endcase
            end
            if (req.valid && req.ready)
                predict_access(req.mode, req.address, req.write_value);
            outstanding <= expected_q.size();
        end
    end

endmodule

[dv/serial_loaded_bank_mapper_tb.sv]
// Testbench top for the bank mapper: clock, reset, access and register stimulus, verdict.
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_tb;

    import slbm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASE_ITEMS = 44;
    localparam int NUM_SETTINGS = 8;

    logic clk;
    logic rst_n;
    int   send_idle = 0;
    int   recv_stall = 0;
    int   hold_asked = 0;
    int   hold_served = 0;
    int   cycles = 0;
    int   sent = 0;
    int   mismatches;
    int   outstanding;

    slbm_req_if req_ch ();
    slbm_rsp_if rsp_ch ();
    slbm_cfg_if cfg_ch ();

    serial_loaded_bank_mapper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    bank_map_checker map_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL serial_loaded_bank_mapper");
            $finish;
        end
    end

    // response side: random stalls, plus long hold-offs on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served < hold_asked)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_access(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] v);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= m;
        req_ch.address     <= a;
        req_ch.write_value <= v;
        do @(posedge clk); while (!req_ch.ready);
        sent++;
    endtask

    // five serial bits, LSB first; only the last transfer's address picks the register
    task automatic serial_load(input logic [ADDR_W-1:0] target, input logic [4:0] value);
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < 5; i++)
        begin
            a = (i == 4) ? target : (16'h8000 | 16'($urandom));
            send_access(MODE_CPU_WRITE, a, {1'b0, 6'($urandom), value[i]});
        end
    endtask

    task automatic random_read();
        case ($urandom_range(9))
            0, 1, 2, 3: send_access(MODE_CPU_READ, 16'h8000 | 16'($urandom), 8'($urandom));
            4:          send_access(MODE_CPU_READ, 16'h6000 + 16'($urandom_range(16'h1FFF)),
                                    8'($urandom));
            5:          send_access(MODE_CPU_WRITE, 16'h6000 + 16'($urandom_range(16'h1FFF)),
                                    8'($urandom));
            6, 7, 8:    send_access(MODE_PPU_READ, 16'($urandom), 8'($urandom));
            default:    send_access(MODE_CPU_READ, 16'($urandom), 8'($urandom));
        endcase
    endtask

    task automatic random_sequence();
        int reads;
        if ($urandom_range(4) == 0)
            send_access(MODE_CPU_WRITE, 16'h8000 | 16'($urandom), 8'h80 | 8'($urandom));
        serial_load(16'h8000 | 16'($urandom), 5'($urandom));
        reads = $urandom_range(1, 3);
        repeat (reads) random_read();
    endtask

    task automatic random_burst(input int count);
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: random_sequence();
                4, 5, 6, 7: random_read();
                default:    send_access(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
            endcase
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] banks, input logic ram);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PRG_ROM_BANKS;
        cfg_ch.data  <= banks;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= CFG_CHR_IS_RAM;
        cfg_ch.data  <= {4'd0, ram};
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] bank_set[NUM_SETTINGS];
        logic                  ram_set[NUM_SETTINGS];
        bank_set = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd7, 5'd16, 5'd5};
        ram_set  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_CPU_READ;
        req_ch.address     = '0;
        req_ch.write_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_PRG_ROM_BANKS;
        cfg_ch.data        = '0;
        do @(posedge clk); while (!rst_n);

        // directed: region edges, ignored writes, reserved mode, serial reset and loads
        send_access(MODE_CPU_READ,  16'h0000, 8'h00);
        send_access(MODE_CPU_READ,  16'h6000, 8'hFF);
        send_access(MODE_CPU_READ,  16'h7FFF, 8'h00);
        send_access(MODE_CPU_READ,  16'h8000, 8'h00);
        send_access(MODE_CPU_READ,  16'hFFFF, 8'h00);
        send_access(MODE_CPU_WRITE, 16'h5FFF, 8'hFF);
        send_access(MODE_CPU_WRITE, 16'h7FFF, 8'h00);
        send_access(MODE_PPU_READ,  16'hFFFF, 8'hFF);
        send_access(MODE_RESERVED,  16'hFFFF, 8'hFF);
        send_access(MODE_CPU_WRITE, 16'h8000, 8'h80);
        serial_load(16'hE000, 5'h1F);
        serial_load(16'h8000, 5'h17);
        send_access(MODE_CPU_READ,  16'hC000, 8'h00);
        send_access(MODE_PPU_READ,  16'h1FFF, 8'h00);

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            drain();
            write_settings(bank_set[s], ram_set[s]);
            for (int p = 0; p < 4; p++)
            begin
                case (p)
                    0:
                    begin
                        send_idle  <= 0;
                        recv_stall <= 0;
                    end
                    1:
                    begin
                        send_idle  <= 54;
                        recv_stall <= 0;
                    end
                    2:
                    begin
                        send_idle  <= 0;
                        recv_stall <= 54;
                    end
                    default:
                    begin
                        send_idle  <= 12;
                        recv_stall <= 12;
                    end
                endcase
                if (p == 0 && (s == 2 || s == 5))
                    hold_asked <= hold_asked + 1;
                random_burst(PHASE_ITEMS);
                if (p == 1 && s == 4)
                    drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS serial_loaded_bank_mapper");
        else
            $display("FAIL serial_loaded_bank_mapper");
        $finish;
    end

endmodule
